### rtl/ptcr_pkg.sv
// ============================================================================
// ptcr_pkg: shared types, constants and a function for the text cell renderer
// Register indexes, beat payload structs and the plane data byte selection.
// ============================================================================
package ptcr_pkg;

    localparam int MAX_PLANES       = 8;
    localparam int PLANE_STEP_BYTES = 2;
    localparam int PLANE_W          = $clog2(MAX_PLANES);
    localparam int COUNT_W          = 4;
    localparam int OFFSET_W         = 24;
    localparam int CFG_INDEX_W      = 4;
    localparam int CFG_DATA_W       = 19;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PLANE_COUNT      = 4'd0,
        REG_FOREGROUND_COLOR = 4'd1,
        REG_BACKGROUND_COLOR = 4'd2,
        REG_REVERSE_VIDEO    = 4'd3,
        REG_LINE_BYTES       = 4'd4,
        REG_CELL_ROW_BYTES   = 4'd5,
        REG_MAX_COLUMN       = 4'd6,
        REG_MAX_ROW          = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic [3:0]  plane_count;
        logic [7:0]  foreground_color;
        logic [7:0]  background_color;
        logic        reverse_video;
        logic [13:0] line_bytes;
        logic [18:0] cell_row_bytes;
        logic [7:0]  max_column;
        logic [7:0]  max_row;
    } cfg_t;

    typedef struct packed {
        logic [7:0] column;
        logic [7:0] row;
        logic [4:0] glyph_row_index;
        logic [7:0] glyph_bits;
    } in_beat_t;

    typedef struct packed {
        logic [23:0] byte_offset;
        logic [7:0]  data_byte;
        logic [2:0]  plane_index;
        logic        last_plane;
    } out_beat_t;

    // One classified item: base offset plus what the plane loop needs
    typedef struct packed {
        logic [OFFSET_W-1:0] base;
        logic [7:0]          fg;
        logic [7:0]          bg;
        logic [7:0]          glyph;
        logic [COUNT_W-1:0]  planes;
    } job_t;

    // Data byte for one plane from its foreground and background bits
    function automatic logic [7:0] plane_byte(input logic fg, input logic bg,
                                              input logic [7:0] glyph);
        logic [7:0] res;
        if (bg && fg)
            res = 8'hFF;
        else if (bg)
            res = ~glyph;
        else if (fg)
            res = glyph;
        else
            res = 8'h00;
        return res;
    endfunction

endpackage

### rtl/ptcr_front.sv
// ============================================================================
// ptcr_front: input stage of the text cell renderer
// Clips the cell position, resolves colors and computes the base offset.
// ============================================================================
module ptcr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  ptcr_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  ptcr_pkg::in_beat_t in_data,
    output logic              push,
    output ptcr_pkg::job_t    push_job,
    input  logic              queue_full
);

    // stage 1: clipped position and resolved colors
    logic                              s1_valid_reg;
    logic [7:0]                        s1_col_reg;
    logic [7:0]                        s1_row_reg;
    logic [4:0]                        s1_gri_reg;
    logic [7:0]                        s1_glyph_reg;
    logic [ptcr_pkg::COUNT_W-1:0]      s1_planes_reg;
    logic [7:0]                        s1_fg_reg;
    logic [7:0]                        s1_bg_reg;

    // stage 2: products
    logic                              s2_valid_reg;
    logic [ptcr_pkg::OFFSET_W-1:0]     s2_row_term_reg;
    logic [18:0]                       s2_line_term_reg;
    logic [11:0]                       s2_col_term_reg;
    logic                              s2_col_odd_reg;
    logic [7:0]                        s2_glyph_reg;
    logic [ptcr_pkg::COUNT_W-1:0]      s2_planes_reg;
    logic [7:0]                        s2_fg_reg;
    logic [7:0]                        s2_bg_reg;

    logic                              s1_ready;
    logic                              s2_ready;
    logic                              in_accept;
    logic [ptcr_pkg::COUNT_W-1:0]      planes_clamped;

    assign s2_ready  = !s2_valid_reg || !queue_full;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign in_accept = in_valid && s1_ready;

    // plane count above the maximum behaves as the maximum
    assign planes_clamped = (cfg.plane_count > ptcr_pkg::COUNT_W'(ptcr_pkg::MAX_PLANES))
                          ? ptcr_pkg::COUNT_W'(ptcr_pkg::MAX_PLANES) : cfg.plane_count;

    // stage 1 valid; an item with no planes makes no writes and is dropped here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= in_accept && (planes_clamped != '0);
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_col_reg    <= (in_data.column > cfg.max_column) ? cfg.max_column
                                                               : in_data.column;
            s1_row_reg    <= (in_data.row > cfg.max_row) ? cfg.max_row : in_data.row;
            s1_gri_reg    <= in_data.glyph_row_index;
            s1_glyph_reg  <= in_data.glyph_bits;
            s1_planes_reg <= planes_clamped;
            s1_fg_reg     <= cfg.reverse_video ? cfg.background_color
                                               : cfg.foreground_color;
            s1_bg_reg     <= cfg.reverse_video ? cfg.foreground_color
                                               : cfg.background_color;
        end
    end

    // stage 2: one multiply per term
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_row_term_reg  <= ptcr_pkg::OFFSET_W'(cfg.cell_row_bytes)
                              * ptcr_pkg::OFFSET_W'(s1_row_reg);
            s2_line_term_reg <= 19'(cfg.line_bytes) * 19'(s1_gri_reg);
            s2_col_term_reg  <= 12'(s1_planes_reg) * 12'({s1_col_reg[7:1], 1'b0});
            s2_col_odd_reg   <= s1_col_reg[0];
            s2_glyph_reg     <= s1_glyph_reg;
            s2_planes_reg    <= s1_planes_reg;
            s2_fg_reg        <= s1_fg_reg;
            s2_bg_reg        <= s1_bg_reg;
        end
    end

    // final sum goes straight into the queue
    assign push            = s2_valid_reg && !queue_full;
    assign push_job.base   = s2_row_term_reg
                           + ptcr_pkg::OFFSET_W'(s2_line_term_reg)
                           + ptcr_pkg::OFFSET_W'(s2_col_term_reg)
                           + ptcr_pkg::OFFSET_W'(s2_col_odd_reg);
    assign push_job.fg     = s2_fg_reg;
    assign push_job.bg     = s2_bg_reg;
    assign push_job.glyph  = s2_glyph_reg;
    assign push_job.planes = s2_planes_reg;

endmodule

### rtl/ptcr_queue.sv
// ============================================================================
// ptcr_queue: short job queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ============================================================================
module ptcr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ptcr_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output ptcr_pkg::job_t head
);

    ptcr_pkg::job_t                    entry_reg [ptcr_pkg::QUEUE_DEPTH];
    logic [ptcr_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [ptcr_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [ptcr_pkg::QUEUE_PTR_W:0]    count_reg;
    logic [ptcr_pkg::QUEUE_PTR_W:0]    count_next;

    assign full      = (count_reg == (ptcr_pkg::QUEUE_PTR_W+1)'(ptcr_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && not_empty))
            count_next = count_reg + 1'b1;
        else if (!push && pop && not_empty)
            count_next = count_reg - 1'b1;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && not_empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### rtl/ptcr_back.sv
// ============================================================================
// ptcr_back: plane sequencer of the text cell renderer
// Walks job planes into an output register; one beat per cycle unless stalled.
// ============================================================================
module ptcr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  ptcr_pkg::job_t       job,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ptcr_pkg::out_beat_t  out_data
);

    logic                              cur_valid_reg;
    ptcr_pkg::job_t                    cur_reg;
    logic [ptcr_pkg::PLANE_W-1:0]      plane_reg;
    logic [ptcr_pkg::OFFSET_W-1:0]     offset_reg;
    logic                              out_valid_reg;
    ptcr_pkg::out_beat_t               out_reg;

    logic                              emit;
    logic                              is_last;
    logic                              load;

    assign emit    = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign is_last = ({1'b0, plane_reg} + 1'b1) == cur_reg.planes;
    assign load    = !cur_valid_reg || (emit && is_last);
    assign pop     = load && job_valid;

    // current job tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_valid_reg <= 1'b0;
        else if (load)
            cur_valid_reg <= job_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg    <= job;
            plane_reg  <= '0;
            offset_reg <= job.base;
        end
        else if (emit)
        begin
            plane_reg  <= plane_reg + 1'b1;
            offset_reg <= offset_reg + ptcr_pkg::OFFSET_W'(ptcr_pkg::PLANE_STEP_BYTES);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.byte_offset <= offset_reg;
            out_reg.data_byte   <= ptcr_pkg::plane_byte(cur_reg.fg[plane_reg],
                                                        cur_reg.bg[plane_reg],
                                                        cur_reg.glyph);
            out_reg.plane_index <= plane_reg;
            out_reg.last_plane  <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### rtl/planar_text_cell_render.sv
// An accepted item passes the stage 1 and stage 2 registers, the job queue,
// the current job register and the output register before its first write
// beat. Write beats leave one per cycle while out_stall is low; each item
// gives one beat per plane, and items with a plane count of zero are dropped.
// Reset: asynchronous, active low; configuration returns to its defaults and
// all pipeline, queue and output state is emptied.
// ============================================================================
// planar_text_cell_render: glyph row to interleaved bitplane byte writes
// Configuration registers, front classifier, job queue and plane sequencer.
// ============================================================================
module planar_text_cell_render (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [3:0]           cfg_index,
    input  logic [18:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ptcr_pkg::in_beat_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ptcr_pkg::out_beat_t  out_data
);

    ptcr_pkg::cfg_t   cfg_reg;
    logic             push;
    ptcr_pkg::job_t   push_job;
    logic             queue_full;
    logic             pop;
    logic             job_valid;
    ptcr_pkg::job_t   head_job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plane_count      <= 4'd1;
            cfg_reg.foreground_color <= 8'd1;
            cfg_reg.background_color <= 8'd0;
            cfg_reg.reverse_video    <= 1'b0;
            cfg_reg.line_bytes       <= 14'd80;
            cfg_reg.cell_row_bytes   <= 19'd1280;
            cfg_reg.max_column       <= 8'd79;
            cfg_reg.max_row          <= 8'd24;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ptcr_pkg::REG_PLANE_COUNT:      cfg_reg.plane_count      <= cfg_data[3:0];
                ptcr_pkg::REG_FOREGROUND_COLOR: cfg_reg.foreground_color <= cfg_data[7:0];
                ptcr_pkg::REG_BACKGROUND_COLOR: cfg_reg.background_color <= cfg_data[7:0];
                ptcr_pkg::REG_REVERSE_VIDEO:    cfg_reg.reverse_video    <= cfg_data[0];
                ptcr_pkg::REG_LINE_BYTES:       cfg_reg.line_bytes       <= cfg_data[13:0];
                ptcr_pkg::REG_CELL_ROW_BYTES:   cfg_reg.cell_row_bytes   <= cfg_data;
                ptcr_pkg::REG_MAX_COLUMN:       cfg_reg.max_column       <= cfg_data[7:0];
                ptcr_pkg::REG_MAX_ROW:          cfg_reg.max_row          <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ptcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    ptcr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (job_valid),
        .head      (head_job)
    );

    ptcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### tb/sv/planar_text_cell_render_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// planar_text_cell_render_checker: write beat predictor and scoreboard
// Watches the register port and both beat channels, keeps a shadow of the
// register file, works out the plane writes of every accepted glyph row and
// compares each accepted write beat with the oldest one still expected.
// ============================================================================
module planar_text_cell_render_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [3:0]          cfg_index,
    input  logic [18:0]         cfg_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  ptcr_pkg::in_beat_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  ptcr_pkg::out_beat_t out_data,
    output int                  fail_count,
    output int                  pending
);

    ptcr_pkg::cfg_t      shadow_regs;
    ptcr_pkg::out_beat_t plane_writes_q[$];

    // Expected plane writes for one glyph row under the current registers
    task automatic queue_plane_writes(input ptcr_pkg::in_beat_t beat);
        logic [7:0]          col;
        logic [7:0]          row;
        logic [3:0]          planes;
        logic [7:0]          fg;
        logic [7:0]          bg;
        logic [31:0]         base;
        ptcr_pkg::out_beat_t wr;
        planes = (shadow_regs.plane_count > ptcr_pkg::MAX_PLANES)
               ? 4'(ptcr_pkg::MAX_PLANES) : shadow_regs.plane_count;
        col = (beat.column > shadow_regs.max_column) ? shadow_regs.max_column : beat.column;
        row = (beat.row > shadow_regs.max_row) ? shadow_regs.max_row : beat.row;
        if (shadow_regs.reverse_video)
        begin
            fg = shadow_regs.background_color;
            bg = shadow_regs.foreground_color;
        end
        else
        begin
            fg = shadow_regs.foreground_color;
            bg = shadow_regs.background_color;
        end
        // wraps at 2^24, so 32 bits of headroom is plenty
        base = shadow_regs.cell_row_bytes * row + planes * {col[7:1], 1'b0} + col[0]
             + beat.glyph_row_index * shadow_regs.line_bytes;
        for (int p = 0; p < planes; p++)
        begin
            wr.byte_offset = base[23:0] + 24'(ptcr_pkg::PLANE_STEP_BYTES * p);
            case ({fg[p], bg[p]})
                2'b11:   wr.data_byte = 8'hFF;
                2'b01:   wr.data_byte = ~beat.glyph_bits;
                2'b10:   wr.data_byte = beat.glyph_bits;
                default: wr.data_byte = 8'h00;
            endcase
            wr.plane_index = 3'(p);
            wr.last_plane  = (p + 1 == planes);
            plane_writes_q.push_back(wr);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_regs.plane_count      = 4'd1;
            shadow_regs.foreground_color = 8'd1;
            shadow_regs.background_color = 8'd0;
            shadow_regs.reverse_video    = 1'b0;
            shadow_regs.line_bytes       = 14'd80;
            shadow_regs.cell_row_bytes   = 19'd1280;
            shadow_regs.max_column       = 8'd79;
            shadow_regs.max_row          = 8'd24;
            plane_writes_q.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            // register shadow; unused indexes fall through
            if (cfg_write)
            begin
                case (cfg_index)
                    ptcr_pkg::REG_PLANE_COUNT:
                        shadow_regs.plane_count      = cfg_data[3:0];
                    ptcr_pkg::REG_FOREGROUND_COLOR:
                        shadow_regs.foreground_color = cfg_data[7:0];
                    ptcr_pkg::REG_BACKGROUND_COLOR:
                        shadow_regs.background_color = cfg_data[7:0];
                    ptcr_pkg::REG_REVERSE_VIDEO:
                        shadow_regs.reverse_video    = cfg_data[0];
                    ptcr_pkg::REG_LINE_BYTES:
                        shadow_regs.line_bytes       = cfg_data[13:0];
                    ptcr_pkg::REG_CELL_ROW_BYTES:
                        shadow_regs.cell_row_bytes   = cfg_data[18:0];
                    ptcr_pkg::REG_MAX_COLUMN:
                        shadow_regs.max_column       = cfg_data[7:0];
                    ptcr_pkg::REG_MAX_ROW:
                        shadow_regs.max_row          = cfg_data[7:0];
                    default: ;
                endcase
            end

            // write beat against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (plane_writes_q.size() == 0)
                begin
                    $error("unexpected write beat: offset %h data %h plane %0d last %0d",
                           out_data.byte_offset, out_data.data_byte,
                           out_data.plane_index, out_data.last_plane);
                    fail_count++;
                end
                else
                begin
                    ptcr_pkg::out_beat_t want;
                    want = plane_writes_q.pop_front();
                    if (out_data.byte_offset !== want.byte_offset)
                    begin
                        $error("byte_offset: expected %h, actual %h",
                               want.byte_offset, out_data.byte_offset);
                        fail_count++;
                    end
                    if (out_data.data_byte !== want.data_byte)
                    begin
                        $error("data_byte: expected %h, actual %h",
                               want.data_byte, out_data.data_byte);
                        fail_count++;
                    end
                    if (out_data.plane_index !== want.plane_index)
                    begin
                        $error("plane_index: expected %0d, actual %0d",
                               want.plane_index, out_data.plane_index);
                        fail_count++;
                    end
                    if (out_data.last_plane !== want.last_plane)
                    begin
                        $error("last_plane: expected %0d, actual %0d",
                               want.last_plane, out_data.last_plane);
                        fail_count++;
                    end
                end
            end

            // glyph row beat
            if (in_valid && !in_stall)
                queue_plane_writes(in_data);

            pending <= plane_writes_q.size();
        end
    end

endmodule

### tb/sv/planar_text_cell_render_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// planar_text_cell_render_tb: regression for the text cell plane renderer
// Directed glyph rows over register extremes, then randomized register sets
// and glyph rows with random idle on both channels; the checker scores beats.
// ============================================================================
module planar_text_cell_render_tb;

    localparam int          DRAIN_CYCLES    = 16;
    localparam logic [3:0]  FIRST_UNUSED_REG = 4'd8;
    localparam int          RANDOM_PHASES   = 8;
    localparam int          ROWS_PER_PHASE  = 44;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [3:0]          cfg_index = '0;
    logic [18:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    ptcr_pkg::in_beat_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    ptcr_pkg::out_beat_t out_data;
    int                  fail_count;
    int                  pending;
    logic                no_idle = 1'b0;

    always #5 clk = ~clk;

    planar_text_cell_render uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    planar_text_cell_render_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Write side back-pressure
    always @(posedge clk)
        out_stall <= !no_idle && ($urandom_range(99) < 7);

    // One register write; unused upper data bits carry junk
    task automatic write_reg(input logic [3:0] idx, input logic [18:0] value,
                             input int width);
        logic [31:0] mask;
        logic [18:0] word;
        mask = (32'd1 << width) - 1;
        word = 19'(($urandom & ~mask) | (value & mask));
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
    endtask

    task automatic apply_settings(input ptcr_pkg::cfg_t s);
        write_reg(ptcr_pkg::REG_PLANE_COUNT,      19'(s.plane_count),      4);
        write_reg(ptcr_pkg::REG_FOREGROUND_COLOR, 19'(s.foreground_color), 8);
        write_reg(ptcr_pkg::REG_BACKGROUND_COLOR, 19'(s.background_color), 8);
        write_reg(ptcr_pkg::REG_REVERSE_VIDEO,    19'(s.reverse_video),    1);
        write_reg(ptcr_pkg::REG_LINE_BYTES,       19'(s.line_bytes),       14);
        write_reg(ptcr_pkg::REG_CELL_ROW_BYTES,   s.cell_row_bytes,        19);
        write_reg(ptcr_pkg::REG_MAX_COLUMN,       19'(s.max_column),       8);
        write_reg(ptcr_pkg::REG_MAX_ROW,          19'(s.max_row),          8);
        // unused index must leave everything alone
        write_reg(4'($urandom_range(FIRST_UNUSED_REG, 15)), 19'($urandom), 19);
        cfg_write <= 1'b0;
    endtask

    function automatic ptcr_pkg::cfg_t make_settings(
        input logic [3:0] pc, input logic [7:0] fg,
        input logic [7:0] bg, input logic rv,
        input logic [13:0] lb, input logic [18:0] crb,
        input logic [7:0] mc, input logic [7:0] mr);
        ptcr_pkg::cfg_t s;
        s.plane_count      = pc;
        s.foreground_color = fg;
        s.background_color = bg;
        s.reverse_video    = rv;
        s.line_bytes       = lb;
        s.cell_row_bytes   = crb;
        s.max_column       = mc;
        s.max_row          = mr;
        return s;
    endfunction

    function automatic ptcr_pkg::cfg_t random_settings();
        ptcr_pkg::cfg_t s;
        // mostly the usual 1/2/4/8 planes, sometimes anything 0..15
        if ($urandom_range(9) < 8)
            s.plane_count = 4'(1 << $urandom_range(3));
        else
            s.plane_count = 4'($urandom_range(15));
        s.foreground_color = 8'($urandom);
        s.background_color = 8'($urandom);
        s.reverse_video    = 1'($urandom_range(1));
        s.line_bytes       = $urandom_range(1) ? 14'($urandom_range(200)) : 14'($urandom);
        s.cell_row_bytes   = $urandom_range(1) ? 19'($urandom_range(4000)) : 19'($urandom);
        case ($urandom_range(3))
            0:       s.max_column = 8'hFF;
            1:       s.max_column = 8'($urandom_range(15));
            default: s.max_column = 8'($urandom);
        endcase
        case ($urandom_range(3))
            0:       s.max_row = 8'hFF;
            1:       s.max_row = 8'($urandom_range(15));
            default: s.max_row = 8'($urandom);
        endcase
        return s;
    endfunction

    // Present one glyph row beat and hold it until taken
    task automatic send_row(input logic [7:0] col, input logic [7:0] row,
                            input logic [4:0] gri, input logic [7:0] glyph);
        int gap;
        ptcr_pkg::in_beat_t beat;
        gap = 0;
        while (!no_idle && $urandom_range(99) < 7)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.column          = col;
        beat.row             = row;
        beat.glyph_row_index = gri;
        beat.glyph_bits      = glyph;
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random_row();
        send_row(8'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
    endtask

    // Wait for all writes, then let a dropped zero-plane row clear the pipe
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: one plane, fg 1, clipping at 79/24
        send_row(8'd0,   8'd0,   5'd0,  8'h00);
        send_row(8'd255, 8'd255, 5'd31, 8'hFF);
        send_row(8'd79,  8'd24,  5'd5,  8'hA5);
        send_row(8'd1,   8'd25,  5'd17, 8'h81);
        drain();

        // eight planes covering all four fg/bg combinations, largest strides
        apply_settings(make_settings(4'd8, 8'hCC, 8'hAA, 1'b0, 14'h3FFF, 19'h7FFFF,
                                     8'hFF, 8'hFF));
        send_row(8'd255, 8'd255, 5'd31, 8'hFF);
        send_row(8'd0,   8'd0,   5'd0,  8'h00);
        send_row(8'd254, 8'd128, 5'd17, 8'h3C);
        send_row(8'd1,   8'd1,   5'd1,  8'h96);
        drain();

        // plane count above the maximum, reverse video, zero strides and maxima
        apply_settings(make_settings(4'd15, 8'hCC, 8'hAA, 1'b1, 14'd0, 19'd0,
                                     8'd0, 8'd0));
        send_row(8'd255, 8'd255, 5'd31, 8'hC3);
        send_row(8'd7,   8'd9,   5'd3,  8'h0F);
        drain();

        // zero planes: rows produce nothing
        apply_settings(make_settings(4'd0, 8'hFF, 8'hFF, 1'b0, 14'd80, 19'd1280,
                                     8'd79, 8'd24));
        send_row(8'd3, 8'd4, 5'd2, 8'h55);
        send_row(8'd200, 8'd200, 5'd31, 8'hAA);
        drain();

        // nine planes clip to eight; two planes background-only
        apply_settings(make_settings(4'd9, 8'hFF, 8'h00, 1'b0, 14'd160, 19'd5120,
                                     8'd127, 8'd63));
        send_row(8'd127, 8'd63, 5'd15, 8'h5A);
        send_row(8'd128, 8'd64, 5'd16, 8'hA5);
        drain();
        apply_settings(make_settings(4'd2, 8'h00, 8'hFF, 1'b0, 14'd40, 19'd640,
                                     8'd39, 8'd24));
        send_row(8'd39, 8'd24, 5'd7, 8'hF0);
        send_row(8'd40, 8'd30, 5'd8, 8'h0F);
        drain();

        // randomized register sets with random rows; one phase runs without idle
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            apply_settings(random_settings());
            no_idle <= (ph == 4);
            for (int n = 0; n < ROWS_PER_PHASE; n++)
                send_random_row();
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
rtl/ptcr_pkg.sv
rtl/ptcr_front.sv
rtl/ptcr_queue.sv
rtl/ptcr_back.sv
rtl/planar_text_cell_render.sv
tb/sv/planar_text_cell_render_checker.sv
tb/sv/planar_text_cell_render_tb.sv
